[rtl/sgm_pkg.sv]
// ----------------------------------------------------------------------------
// Sobel gradient magnitude: shared package
// Register codes, field widths, reset values and the Sobel tap helper.
// ----------------------------------------------------------------------------
package sgm_pkg;

   localparam int PIXEL_W        = 8;
   localparam int MAG_W          = 8;
   localparam int LINE_WIDTH_W   = 11;
   localparam int FRAME_HEIGHT_W = 13;
   localparam int CSR_DATA_W     = 13;
   localparam int CSR_INDEX_W    = 1;
   localparam int TAP_W          = PIXEL_W + 2;
   localparam int GRAD_W         = TAP_W + 1;
   localparam int SQ_W           = 2 * TAP_W;
   localparam int ROOT_IN_W      = 2 * MAG_W;
   localparam int ROOT_STEPS     = MAG_W;
   localparam int MIN_DIM        = 3;
   localparam int RSP_FIFO_DEPTH = 16;

   localparam logic [LINE_WIDTH_W-1:0]   LINE_WIDTH_RESET   = 11'd512;
   localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RESET = 13'd512;
   localparam logic [MAG_W-1:0]          MAG_MAX            = 8'd255;

   typedef logic [PIXEL_W-1:0] pixel_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LINE_WIDTH   = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   // Request into the square root pipeline.
   typedef struct packed {
      logic                 valid;
      logic                 sat;
      logic [ROOT_IN_W-1:0] root_in;
   } root_req_type;

   // Weighted 1-2-1 sum of three pixels.
   function automatic logic [TAP_W-1:0] sobel_tap(input pixel_type a, input pixel_type b,
                                                  input pixel_type c);
      return TAP_W'(a) + (TAP_W'(b) << 1) + TAP_W'(c);
   endfunction

endpackage

[rtl/sgm_if.sv]
// ----------------------------------------------------------------------------
// Sobel gradient magnitude: stream interfaces
// Pixel request channel and magnitude response channel, valid/ready.
// ----------------------------------------------------------------------------
interface sgm_req_if;
   logic                            valid;
   logic                            ready;
   logic [sgm_pkg::PIXEL_W-1:0]     pixel;

   modport source (output valid, output pixel, input ready);
   modport sink   (input valid, input pixel, output ready);
endinterface

interface sgm_rsp_if #(
   parameter int ROW_W = 12,
   parameter int COL_W = 10
);
   logic                            valid;
   logic                            ready;
   logic [sgm_pkg::MAG_W-1:0]       magnitude;
   logic [ROW_W-1:0]                centre_row;
   logic [COL_W-1:0]                centre_col;
   logic                            last_of_frame;

   modport source (output valid, output magnitude, output centre_row, output centre_col,
                   output last_of_frame, input ready);
   modport sink   (input valid, input magnitude, input centre_row, input centre_col,
                   input last_of_frame, output ready);
endinterface

[rtl/sgm_line_buffer.sv]
// ----------------------------------------------------------------------------
// Sobel gradient magnitude: line buffer
// One synchronous memory holding the two previous rows side by side, with
// write-to-read forwarding when both ports hit the same column.
// ----------------------------------------------------------------------------
module sgm_line_buffer #(
   parameter int DEPTH = 1024
) (
   input  logic                              clock,
   input  logic                              rd_en,
   input  logic [$clog2(DEPTH)-1:0]          rd_addr,
   output logic [2*sgm_pkg::PIXEL_W-1:0]     rd_data,
   input  logic                              wr_en,
   input  logic [$clog2(DEPTH)-1:0]          wr_addr,
   input  logic [2*sgm_pkg::PIXEL_W-1:0]     wr_data
);

   // Upper row in the high byte, middle row in the low byte.
   logic [2*sgm_pkg::PIXEL_W-1:0] mem_ff [DEPTH];
   logic [2*sgm_pkg::PIXEL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/sgm_gradient.sv]
// ----------------------------------------------------------------------------
// Sobel gradient magnitude: sum of squares
// Two stages: absolute value and square of gx and gy, then their sum with
// the saturation flag for sums that need more than sixteen bits.
// ----------------------------------------------------------------------------
module sgm_gradient #(
   parameter int TAG_W = 23
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   input  logic signed [sgm_pkg::GRAD_W-1:0]     in_gx,
   input  logic signed [sgm_pkg::GRAD_W-1:0]     in_gy,
   input  logic [TAG_W-1:0]                      in_tag,
   output sgm_pkg::root_req_type                 out_req,
   output logic [TAG_W-1:0]                      out_tag
);

   localparam int ABS_W = sgm_pkg::TAP_W;
   localparam int SUM_W = sgm_pkg::SQ_W + 1;

   logic [ABS_W-1:0]            abs_x;
   logic [ABS_W-1:0]            abs_y;
   logic                        sq_valid_ff;
   logic [sgm_pkg::SQ_W-1:0]    sq_x_ff;
   logic [sgm_pkg::SQ_W-1:0]    sq_y_ff;
   logic [TAG_W-1:0]            sq_tag_ff;
   logic [SUM_W-1:0]            sum_in;
   sgm_pkg::root_req_type       req_ff;
   logic [TAG_W-1:0]            tag_ff;

   assign abs_x = in_gx[sgm_pkg::GRAD_W-1] ? ABS_W'(-in_gx) : ABS_W'(in_gx);
   assign abs_y = in_gy[sgm_pkg::GRAD_W-1] ? ABS_W'(-in_gy) : ABS_W'(in_gy);

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= 1'b0;
      end else begin
         sq_valid_ff <= in_valid;
      end
      sq_x_ff   <= sgm_pkg::SQ_W'(abs_x) * sgm_pkg::SQ_W'(abs_x);
      sq_y_ff   <= sgm_pkg::SQ_W'(abs_y) * sgm_pkg::SQ_W'(abs_y);
      sq_tag_ff <= in_tag;
   end

   assign sum_in = SUM_W'(sq_x_ff) + SUM_W'(sq_y_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         req_ff.valid <= 1'b0;
      end else begin
         req_ff.valid <= sq_valid_ff;
      end
      req_ff.sat     <= |sum_in[SUM_W-1:sgm_pkg::ROOT_IN_W];
      req_ff.root_in <= sum_in[sgm_pkg::ROOT_IN_W-1:0];
      tag_ff         <= sq_tag_ff;
   end

   assign out_req = req_ff;
   assign out_tag = tag_ff;

endmodule

[rtl/sgm_isqrt.sv]
// ----------------------------------------------------------------------------
// Sobel gradient magnitude: integer square root
// Pipelined bit-by-bit root, one result bit per stage from the top down.
// The running square is kept so each stage only adds and compares.
// ----------------------------------------------------------------------------
module sgm_isqrt #(
   parameter int TAG_W = 23
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sgm_pkg::root_req_type         in_req,
   input  logic [TAG_W-1:0]              in_tag,
   output logic                          out_valid,
   output logic [sgm_pkg::MAG_W-1:0]     out_magnitude,
   output logic [TAG_W-1:0]              out_tag
);

   localparam int STEPS = sgm_pkg::ROOT_STEPS;
   localparam int RW    = sgm_pkg::MAG_W;
   localparam int SW    = sgm_pkg::ROOT_IN_W;

   logic            valid_ff [STEPS];
   logic            sat_ff   [STEPS];
   logic [SW-1:0]   s_ff     [STEPS];
   logic [RW-1:0]   r_ff     [STEPS];
   logic [SW-1:0]   r2_ff    [STEPS];
   logic [TAG_W-1:0] tag_ff  [STEPS];

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      localparam int B = STEPS - 1 - i;

      logic             valid_prev;
      logic             sat_prev;
      logic [SW-1:0]    s_prev;
      logic [RW-1:0]    r_prev;
      logic [SW-1:0]    r2_prev;
      logic [TAG_W-1:0] tag_prev;
      logic [RW-1:0]    trial;
      logic [SW-1:0]    trial_sq;

      if (i == 0) begin : g_first
         assign valid_prev = in_req.valid;
         assign sat_prev   = in_req.sat;
         assign s_prev     = in_req.root_in;
         assign r_prev     = '0;
         assign r2_prev    = '0;
         assign tag_prev   = in_tag;
      end else begin : g_next
         assign valid_prev = valid_ff[i-1];
         assign sat_prev   = sat_ff[i-1];
         assign s_prev     = s_ff[i-1];
         assign r_prev     = r_ff[i-1];
         assign r2_prev    = r2_ff[i-1];
         assign tag_prev   = tag_ff[i-1];
      end

      // (r + 2^B)^2 = r^2 + r * 2^(B+1) + 2^(2B); the trial root stays below 256.
      assign trial    = r_prev | (RW'(1) << B);
      assign trial_sq = r2_prev + (SW'(r_prev) << (B + 1)) + (SW'(1) << (2 * B));

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else begin
            valid_ff[i] <= valid_prev;
         end
         sat_ff[i] <= sat_prev;
         s_ff[i]   <= s_prev;
         tag_ff[i] <= tag_prev;
         if (trial_sq <= s_prev) begin
            r_ff[i]  <= trial;
            r2_ff[i] <= trial_sq;
         end else begin
            r_ff[i]  <= r_prev;
            r2_ff[i] <= r2_prev;
         end
      end
   end

   assign out_valid     = valid_ff[STEPS-1];
   assign out_magnitude = sat_ff[STEPS-1] ? sgm_pkg::MAG_MAX : r_ff[STEPS-1];
   assign out_tag       = tag_ff[STEPS-1];

endmodule

[rtl/sgm_result_fifo.sv]
// ----------------------------------------------------------------------------
// Sobel gradient magnitude: result FIFO
// Holds finished results until the response side takes them. The writer
// never overruns it because the input side only takes items it has room for.
// ----------------------------------------------------------------------------
module sgm_result_fifo #(
   parameter int WIDTH = 31,
   parameter int DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [WIDTH-1:0]  in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [WIDTH-1:0]  out_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (in_valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      count_in = count_ff + CNT_W'(in_valid) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

[rtl/sobel_gradient_magnitude_core.sv]
// ----------------------------------------------------------------------------
// Sobel gradient magnitude core
// Streams 8-bit pixels in raster order through a two-row line store and a 3x3
// window, and returns the saturated integer gradient magnitude for every
// interior pixel with its position and an end-of-frame flag.
//
//   channel    direction  carries
//   req_chan   in         pixel
//   rsp_chan   out        magnitude, centre_row, centre_col, last_of_frame
//   csr_*      in         line_width (index 0), frame_height (index 1)
//
// One pixel is taken per clock unless the input stalls; the line store is a single
// read-modify-write memory whose read is forwarded from the write of the prior item.
// A result passes the read, window, square and sum stages, then eight square root
// stages and the result FIFO. Up to 16 items may be pending at once; the input
// stalls only when that many are in flight or waiting in the result FIFO.
// Reset clears counters, window and FIFO; the line store is not cleared, its
// first two rows of each frame are written before any result reads them.
// ----------------------------------------------------------------------------
module sobel_gradient_magnitude_core #(
   parameter int MAX_LINE_WIDTH   = 1024,
   parameter int MAX_FRAME_HEIGHT = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   sgm_req_if.sink                           req_chan,
   sgm_rsp_if.source                         rsp_chan,
   input  logic                              csr_wr_en,
   input  logic [sgm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [sgm_pkg::CSR_DATA_W-1:0]    csr_wr_data
);

   localparam int COL_W   = $clog2(MAX_LINE_WIDTH);
   localparam int ROW_W   = $clog2(MAX_FRAME_HEIGHT);
   localparam int CNT_C_W = $clog2(MAX_LINE_WIDTH + 1);
   localparam int CNT_R_W = $clog2(MAX_FRAME_HEIGHT + 1);
   localparam int TAG_W   = 1 + ROW_W + COL_W;
   localparam int OCC_W   = $clog2(sgm_pkg::RSP_FIFO_DEPTH + 1);
   localparam int PW      = sgm_pkg::PIXEL_W;
   localparam int FIFO_W  = sgm_pkg::MAG_W + TAG_W;

   // Configuration registers.
   logic [sgm_pkg::LINE_WIDTH_W-1:0]   line_width_ff;
   logic [sgm_pkg::FRAME_HEIGHT_W-1:0] frame_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff   <= sgm_pkg::LINE_WIDTH_RESET;
         frame_height_ff <= sgm_pkg::FRAME_HEIGHT_RESET;
      end else if (csr_wr_en) begin
         case (sgm_pkg::csr_index_type'(csr_index))
            sgm_pkg::CSR_LINE_WIDTH: begin
               line_width_ff <= csr_wr_data[sgm_pkg::LINE_WIDTH_W-1:0];
            end
            sgm_pkg::CSR_FRAME_HEIGHT: begin
               frame_height_ff <= csr_wr_data[sgm_pkg::FRAME_HEIGHT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Position counters.
   logic [COL_W-1:0]   col_ff;
   logic [ROW_W-1:0]   row_ff;
   logic [CNT_C_W-1:0] w_eff, col_pre, col_post;
   logic [CNT_R_W-1:0] h_eff, row_pre, row_post;
   logic               accept;
   logic               emit;
   logic               last;
   logic [TAG_W-1:0]   tag;

   always_comb begin
      if (32'(line_width_ff) < 32'(sgm_pkg::MIN_DIM)) begin
         w_eff = CNT_C_W'(sgm_pkg::MIN_DIM);
      end else if (32'(line_width_ff) > 32'(MAX_LINE_WIDTH)) begin
         w_eff = CNT_C_W'(MAX_LINE_WIDTH);
      end else begin
         w_eff = CNT_C_W'(line_width_ff);
      end
      if (32'(frame_height_ff) < 32'(sgm_pkg::MIN_DIM)) begin
         h_eff = CNT_R_W'(sgm_pkg::MIN_DIM);
      end else if (32'(frame_height_ff) > 32'(MAX_FRAME_HEIGHT)) begin
         h_eff = CNT_R_W'(MAX_FRAME_HEIGHT);
      end else begin
         h_eff = CNT_R_W'(frame_height_ff);
      end

      // A counter left out of range by a new size wraps before use.
      col_pre = CNT_C_W'(col_ff);
      row_pre = CNT_R_W'(row_ff);
      if (col_pre >= w_eff) begin
         col_pre = '0;
         row_pre = row_pre + CNT_R_W'(1);
      end
      if (row_pre >= h_eff) begin
         row_pre = '0;
      end

      col_post = col_pre + CNT_C_W'(1);
      row_post = row_pre;
      if (col_post >= w_eff) begin
         col_post = '0;
         row_post = row_pre + CNT_R_W'(1);
         if (row_post >= h_eff) begin
            row_post = '0;
         end
      end

      emit = (row_pre >= CNT_R_W'(2)) && (col_pre >= CNT_C_W'(2));
      last = (row_pre == h_eff - CNT_R_W'(1)) && (col_pre == w_eff - CNT_C_W'(1));
      tag  = {last, ROW_W'(row_pre - CNT_R_W'(1)), COL_W'(col_pre - CNT_C_W'(1))};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= COL_W'(col_post);
         row_ff <= ROW_W'(row_post);
      end
   end

   // Stage 1: line store read in flight.
   logic               s1_valid_ff;
   logic [PW-1:0]      s1_pixel_ff;
   logic [COL_W-1:0]   s1_addr_ff;
   logic               s1_emit_ff;
   logic [TAG_W-1:0]   s1_tag_ff;
   logic [2*PW-1:0]    line_rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
      if (accept) begin
         s1_pixel_ff <= req_chan.pixel;
         s1_addr_ff  <= COL_W'(col_pre);
         s1_emit_ff  <= emit;
         s1_tag_ff   <= tag;
      end
   end

   sgm_line_buffer #(
      .DEPTH (MAX_LINE_WIDTH)
   ) u_line_buffer (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (COL_W'(col_pre)),
      .rd_data (line_rd_data),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_addr_ff),
      .wr_data ({line_rd_data[PW-1:0], s1_pixel_ff})
   );

   // 3x3 window, [row][col] with row 0 on top and col 0 on the left.
   sgm_pkg::pixel_type win_ff [3][3];
   sgm_pkg::pixel_type win_in [3][3];
   logic signed [sgm_pkg::GRAD_W-1:0] gx_in, gy_in;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         win_in[k][0] = win_ff[k][1];
         win_in[k][1] = win_ff[k][2];
      end
      win_in[0][2] = line_rd_data[2*PW-1:PW];
      win_in[1][2] = line_rd_data[PW-1:0];
      win_in[2][2] = s1_pixel_ff;

      gx_in = $signed({1'b0, sgm_pkg::sobel_tap(win_in[0][0], win_in[1][0], win_in[2][0])})
            - $signed({1'b0, sgm_pkg::sobel_tap(win_in[0][2], win_in[1][2], win_in[2][2])});
      gy_in = $signed({1'b0, sgm_pkg::sobel_tap(win_in[0][0], win_in[0][1], win_in[0][2])})
            - $signed({1'b0, sgm_pkg::sobel_tap(win_in[2][0], win_in[2][1], win_in[2][2])});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
               win_ff[k][j] <= '0;
            end
         end
      end else if (s1_valid_ff) begin
         win_ff <= win_in;
      end
   end

   // Stage 2: gradients of interior pixels only.
   logic                               s2_valid_ff;
   logic signed [sgm_pkg::GRAD_W-1:0]  s2_gx_ff, s2_gy_ff;
   logic [TAG_W-1:0]                   s2_tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff && s1_emit_ff;
      end
      s2_gx_ff  <= gx_in;
      s2_gy_ff  <= gy_in;
      s2_tag_ff <= s1_tag_ff;
   end

   sgm_pkg::root_req_type root_req;
   logic [TAG_W-1:0]      root_tag;
   logic                  res_valid;
   logic [sgm_pkg::MAG_W-1:0] res_magnitude;
   logic [TAG_W-1:0]      res_tag;

   sgm_gradient #(
      .TAG_W (TAG_W)
   ) u_gradient (
      .clock    (clock),
      .reset    (reset),
      .in_valid (s2_valid_ff),
      .in_gx    (s2_gx_ff),
      .in_gy    (s2_gy_ff),
      .in_tag   (s2_tag_ff),
      .out_req  (root_req),
      .out_tag  (root_tag)
   );

   sgm_isqrt #(
      .TAG_W (TAG_W)
   ) u_isqrt (
      .clock         (clock),
      .reset         (reset),
      .in_req        (root_req),
      .in_tag        (root_tag),
      .out_valid     (res_valid),
      .out_magnitude (res_magnitude),
      .out_tag       (res_tag)
   );

   logic [FIFO_W-1:0] fifo_out;

   sgm_result_fifo #(
      .WIDTH (FIFO_W),
      .DEPTH (sgm_pkg::RSP_FIFO_DEPTH)
   ) u_result_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_data   ({res_magnitude, res_tag}),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (fifo_out)
   );

   assign rsp_chan.magnitude     = fifo_out[FIFO_W-1:TAG_W];
   assign rsp_chan.last_of_frame = fifo_out[TAG_W-1];
   assign rsp_chan.centre_row    = fifo_out[ROW_W+COL_W-1:COL_W];
   assign rsp_chan.centre_col    = fifo_out[COL_W-1:0];

   // Items counted from acceptance until they leave as a result or are
   // dropped as border pixels; this keeps the FIFO from overflowing.
   logic [OCC_W-1:0] occ_ff, occ_in;
   logic             drop;
   logic             pop;

   assign accept         = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (occ_ff < OCC_W'(sgm_pkg::RSP_FIFO_DEPTH));
   assign drop           = s1_valid_ff && !s1_emit_ff;
   assign pop            = rsp_chan.valid && rsp_chan.ready;
   assign occ_in         = occ_ff + OCC_W'(accept) - OCC_W'(drop) - OCC_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

endmodule

[rtl/sgm_checker.sv]
// ----------------------------------------------------------------------------
// Sobel gradient magnitude: port checker
// Watches the core's ports for reset behavior, result positions and the
// response handshake.
// ----------------------------------------------------------------------------
module sgm_checker #(
   parameter int ROW_W = 12,
   parameter int COL_W = 10
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [sgm_pkg::MAG_W-1:0]     rsp_magnitude,
   input logic [ROW_W-1:0]              rsp_centre_row,
   input logic [COL_W-1:0]              rsp_centre_col,
   input logic                          rsp_last_of_frame
);

   // After reset nothing is pending, so no result shows and input is open.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("core not empty after reset");

   // Border pixels never produce a result.
   a_interior_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_centre_row != '0) && (rsp_centre_col != '0))
      else $error("result reported for a border pixel");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response valid dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_magnitude) && $stable(rsp_centre_row)
                                  && $stable(rsp_centre_col) && $stable(rsp_last_of_frame))
      else $error("response payload changed while stalled");

endmodule

bind sobel_gradient_magnitude_core sgm_checker #(
   .ROW_W (ROW_W),
   .COL_W (COL_W)
) u_sgm_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_magnitude     (rsp_chan.magnitude),
   .rsp_centre_row    (rsp_chan.centre_row),
   .rsp_centre_col    (rsp_chan.centre_col),
   .rsp_last_of_frame (rsp_chan.last_of_frame)
);

[verif/sgm_gradient_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sobel gradient magnitude: scoreboard
// Watches the pixel and result channels and the register port, keeps its own
// line stores, window and raster counters, and checks every result in order.
// ----------------------------------------------------------------------------
module sgm_gradient_checker
   import sgm_pkg::*;
#(
   parameter int MAX_LINE_WIDTH   = 1024,
   parameter int MAX_FRAME_HEIGHT = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   sgm_req_if                     req_mon,
   sgm_rsp_if                     rsp_mon,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data,
   output int                     mismatch_count,
   output int                     pending_results
);

   typedef struct packed {
      logic [MAG_W-1:0] magnitude;
      logic [11:0]      centre_row;
      logic [9:0]       centre_col;
      logic             last_of_frame;
   } gradient_result_type;

   logic [LINE_WIDTH_W-1:0]   line_width_reg;
   logic [FRAME_HEIGHT_W-1:0] frame_height_reg;
   pixel_type                 row_above [MAX_LINE_WIDTH];
   pixel_type                 row_prev [MAX_LINE_WIDTH];
   pixel_type                 window [3][3];
   int                        col_pos;
   int                        row_pos;
   int                        failures = 0;
   gradient_result_type       gradient_q [$];

   assign mismatch_count = failures;

   function automatic int clamp_dim(input int value, input int lo, input int hi);
      if (value < lo) return lo;
      if (value > hi) return hi;
      return value;
   endfunction

   function automatic logic [MAG_W-1:0] floor_root(input int sum_sq);
      logic [MAG_W-1:0] root;
      logic [MAG_W-1:0] trial;
      if (sum_sq >= 65536) return MAG_MAX;
      root = '0;
      for (int b = MAG_W - 1; b >= 0; b--) begin
         trial = root | (MAG_W'(1) << b);
         if (int'(trial) * int'(trial) <= sum_sq) root = trial;
      end
      return root;
   endfunction

   function automatic void check_field(input string field, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         failures++;
      end
   endfunction

   // Advances the raster by one pixel and queues the magnitude it completes.
   task automatic predict_gradient(input pixel_type px);
      int                  eff_w;
      int                  eff_h;
      int                  gx;
      int                  gy;
      pixel_type           above;
      pixel_type           prev;
      gradient_result_type res;
      eff_w = clamp_dim(int'(line_width_reg), MIN_DIM, MAX_LINE_WIDTH);
      eff_h = clamp_dim(int'(frame_height_reg), MIN_DIM, MAX_FRAME_HEIGHT);
      // A bound lowered since the last pixel wraps the counters first.
      if (col_pos >= eff_w) begin
         col_pos = 0;
         row_pos++;
      end
      if (row_pos >= eff_h) row_pos = 0;

      above = row_above[col_pos];
      prev = row_prev[col_pos];
      row_above[col_pos] = prev;
      row_prev[col_pos] = px;
      for (int k = 0; k < 3; k++) begin
         window[k][0] = window[k][1];
         window[k][1] = window[k][2];
      end
      window[0][2] = above;
      window[1][2] = prev;
      window[2][2] = px;

      if (row_pos >= 2 && col_pos >= 2) begin
         gx = int'(window[0][0]) + 2 * int'(window[1][0]) + int'(window[2][0])
            - int'(window[0][2]) - 2 * int'(window[1][2]) - int'(window[2][2]);
         gy = int'(window[0][0]) + 2 * int'(window[0][1]) + int'(window[0][2])
            - int'(window[2][0]) - 2 * int'(window[2][1]) - int'(window[2][2]);
         res.magnitude = floor_root(gx * gx + gy * gy);
         res.centre_row = 12'(row_pos - 1);
         res.centre_col = 10'(col_pos - 1);
         res.last_of_frame = (row_pos == eff_h - 1) && (col_pos == eff_w - 1);
         gradient_q.push_back(res);
      end

      col_pos++;
      if (col_pos >= eff_w) begin
         col_pos = 0;
         row_pos++;
         if (row_pos >= eff_h) row_pos = 0;
      end
   endtask

   task automatic check_gradient();
      gradient_result_type want;
      if (gradient_q.size() == 0) begin
         $error("unexpected result: magnitude %0d at row %0d, col %0d",
                rsp_mon.magnitude, rsp_mon.centre_row, rsp_mon.centre_col);
         failures++;
      end else begin
         want = gradient_q.pop_front();
         check_field("magnitude", 32'(want.magnitude), 32'(rsp_mon.magnitude));
         check_field("centre_row", 32'(want.centre_row), 32'(rsp_mon.centre_row));
         check_field("centre_col", 32'(want.centre_col), 32'(rsp_mon.centre_col));
         check_field("last_of_frame", 32'(want.last_of_frame), 32'(rsp_mon.last_of_frame));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         line_width_reg = LINE_WIDTH_RESET;
         frame_height_reg = FRAME_HEIGHT_RESET;
         foreach (window[r, c]) window[r][c] = '0;
         col_pos = 0;
         row_pos = 0;
         gradient_q.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_LINE_WIDTH:   line_width_reg = csr_wr_data[LINE_WIDTH_W-1:0];
               CSR_FRAME_HEIGHT: frame_height_reg = csr_wr_data[FRAME_HEIGHT_W-1:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) predict_gradient(req_mon.pixel);
         if (rsp_mon.valid && rsp_mon.ready) check_gradient();
      end
      pending_results <= gradient_q.size();
   end

endmodule

[verif/tb_sobel_gradient_magnitude_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sobel gradient magnitude core: testbench
// Streams whole frames of pixels at several small frame geometries, including
// clamped and truncated register values, with random gaps and result stalls,
// and lets the scoreboard check every magnitude, position and end-of-frame flag.
// ----------------------------------------------------------------------------
module tb_sobel_gradient_magnitude_core;
   import sgm_pkg::*;

   localparam int MAX_LINE_WIDTH   = 1024;
   localparam int MAX_FRAME_HEIGHT = 4096;
   localparam int HALF_PERIOD      = 4;
   localparam int CYCLE_LIMIT      = 400_000;
   localparam int DRAIN_CYCLES     = 32;
   localparam int HOLD_CYCLES      = 300;
   localparam int ITEM_TARGET      = 550;

   typedef enum int {PIX_RANDOM, PIX_EXTREME, PIX_RAMP, PIX_FLAT} pixel_pattern_type;

   // Strong vertical edge: the sum of squares is far past the saturation point.
   localparam pixel_type STEP_FRAME [9] = '{
      8'd255, 8'd128, 8'd0,
      8'd255, 8'd128, 8'd0,
      8'd255, 8'd128, 8'd0
   };
   localparam pixel_type MIXED_FRAME [16] = '{
      8'd0,   8'd255, 8'd255, 8'd0,
      8'd0,   8'd0,   8'd255, 8'd1,
      8'd255, 8'd0,   8'd0,   8'd254,
      8'd0,   8'd255, 8'd0,   8'd255
   };

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_LINE_WIDTH;
   logic [CSR_DATA_W-1:0]  csr_wr_data = '0;
   int                     mismatch_count;
   int                     pending_results;
   int                     cycle_count = 0;
   int                     items_sent = 0;
   int                     eff_w = 3;
   int                     eff_h = 3;
   bit                     req_quiet = 1'b0;
   bit                     rsp_quiet = 1'b0;
   bit                     backpressure_hold = 1'b0;

   sgm_req_if req_bus ();
   sgm_rsp_if rsp_bus ();

   sobel_gradient_magnitude_core #(
      .MAX_LINE_WIDTH   (MAX_LINE_WIDTH),
      .MAX_FRAME_HEIGHT (MAX_FRAME_HEIGHT)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   sgm_gradient_checker #(
      .MAX_LINE_WIDTH   (MAX_LINE_WIDTH),
      .MAX_FRAME_HEIGHT (MAX_FRAME_HEIGHT)
   ) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_bus),
      .rsp_mon         (rsp_bus),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data),
      .mismatch_count  (mismatch_count),
      .pending_results (pending_results)
   );

   always #(HALF_PERIOD) clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic int clamp_dim(input int value, input int lo, input int hi);
      if (value < lo) return lo;
      if (value > hi) return hi;
      return value;
   endfunction

   // Mostly back to back, sometimes a short gap, now and then a long gap.
   function automatic int pick_gap(input bit quiet);
      int roll;
      if (quiet) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 24);
   endfunction

   function automatic pixel_type pattern_pixel(input pixel_pattern_type pattern, input int col,
                                                input int row, input int seed);
      case (pattern)
         PIX_EXTREME: return ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
         PIX_RAMP:    return 8'(col * ((seed & 7) + 1) + row * (seed >> 5)
                                + $urandom_range(0, 3));
         PIX_FLAT:    return 8'(seed);
         default:     return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic write_csr(input csr_index_type index, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wr_data <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Only the low register bits count, and the geometry is clamped to its legal range.
   task automatic set_geometry(input logic [CSR_DATA_W-1:0] width_data,
                               input logic [CSR_DATA_W-1:0] height_data);
      write_csr(CSR_LINE_WIDTH, width_data);
      write_csr(CSR_FRAME_HEIGHT, height_data);
      eff_w = clamp_dim(int'(width_data[LINE_WIDTH_W-1:0]), MIN_DIM, MAX_LINE_WIDTH);
      eff_h = clamp_dim(int'(height_data[FRAME_HEIGHT_W-1:0]), MIN_DIM, MAX_FRAME_HEIGHT);
   endtask

   task automatic send_pixel(input pixel_type value);
      int gap;
      gap = pick_gap(req_quiet);
      repeat (gap) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
      @(negedge clock);
      req_bus.valid <= 1'b1;
      req_bus.pixel <= value;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
   endtask

   task automatic send_frames(input int frames, input pixel_pattern_type pattern);
      int seed;
      for (int f = 0; f < frames; f++) begin
         seed = $urandom_range(0, 255);
         for (int r = 0; r < eff_h; r++)
            for (int c = 0; c < eff_w; c++)
               send_pixel(pattern_pixel(pattern, c, r, seed));
      end
   endtask

   // Phases always end on a frame boundary, so the counters are back at zero
   // and no result of a new geometry uses a line store entry left from an old one.
   task automatic finish_phase();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_results != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      int stall_left;
      int mode_left;
      stall_left = 0;
      mode_left = 64;
      rsp_bus.ready = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (backpressure_hold) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            backpressure_hold = 1'b0;
         end else if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
            stall_left = pick_gap(rsp_quiet);
         end
         mode_left--;
         if (mode_left <= 0) begin
            rsp_quiet = ($urandom_range(0, 3) == 0);
            mode_left = $urandom_range(32, 256);
         end
      end
   end

   initial begin
      int                frames;
      int                roll;
      logic [CSR_DATA_W-1:0] width_data;
      logic [CSR_DATA_W-1:0] height_data;
      req_bus.valid = 1'b0;
      req_bus.pixel = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Smallest frame, then a 4x4 frame of extreme and near-extreme values.
      set_geometry(13'd3, 13'd3);
      foreach (STEP_FRAME[i]) send_pixel(STEP_FRAME[i]);
      finish_phase();
      set_geometry(13'd4, 13'd4);
      foreach (MIXED_FRAME[i]) send_pixel(MIXED_FRAME[i]);
      finish_phase();

      // The receiver holds off for a long stretch while pixels keep coming.
      set_geometry(13'd16, 13'd8);
      req_quiet = 1'b1;
      backpressure_hold = 1'b1;
      send_frames(1, PIX_RANDOM);
      finish_phase();
      req_quiet = 1'b0;

      // Upper width bits are dropped, leaving five columns; a zero height
      // clamps to three rows.
      set_geometry(13'h1805, 13'h0000);
      send_frames(1, PIX_RAMP);
      finish_phase();

      while (items_sent < ITEM_TARGET) begin
         roll = $urandom_range(0, 99);
         width_data = (roll < 15) ? CSR_DATA_W'($urandom_range(0, 2)) :
                      (roll < 80) ? CSR_DATA_W'($urandom_range(3, 16)) :
                                    CSR_DATA_W'($urandom_range(17, 24));
         roll = $urandom_range(0, 99);
         height_data = (roll < 15) ? CSR_DATA_W'($urandom_range(0, 2)) :
                       (roll < 80) ? CSR_DATA_W'($urandom_range(3, 8)) :
                                     CSR_DATA_W'($urandom_range(9, 12));
         set_geometry(width_data, height_data);
         req_quiet = ($urandom_range(0, 4) == 0);
         frames = (items_sent + 2 * eff_w * eff_h <= ITEM_TARGET) ?
                  int'($urandom_range(1, 2)) : 1;
         send_frames(frames, pixel_pattern_type'($urandom_range(0, 3)));
         finish_phase();
      end

      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
